// ===== rtl/core/sab_pkg.sv =====
// Shared types and constants of the suffix automaton builder.
package sab_pkg;

  // String length limit and alphabet size; the field widths below are sized for these.
  localparam int MAX_STRING  = 1024;
  localparam int ALPHABET    = 10;

  // Width of every state index, length and count field on the result channel.
  localparam int FIELD_W     = 11;
  localparam int SYM_W       = 4;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROOT,
    ST_ALLOC,
    ST_NEWLEN,
    ST_WALK,
    ST_QA,
    ST_QB,
    ST_COPY,
    ST_RRD,
    ST_RCHK,
    ST_REND,
    ST_FIN,
    ST_OUT
  } ctl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ROOT,
    OP_ALLOC,
    OP_NEWLEN,
    OP_WALK,
    OP_QA,
    OP_QB,
    OP_COPY,
    OP_RRD,
    OP_RCHK,
    OP_REND,
    OP_FIN,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic ovf;       // length limit reached or symbol out of range
    logic bit_set;   // transition on the symbol present in the row just read
    logic p_zero;    // walk pointer is at the root
    logic len_match; // len(q) == len(p) + 1
    logic redir_hit; // transition on the symbol still points at q
    logic k_last;    // last transition of the clone copy
    logic out_free;  // output register can take a result this cycle
  } dp_status_t;

endpackage

// ===== rtl/core/suffix_automaton_builder_core.sv =====
// Top level of the suffix automaton builder: sequencer plus datapath.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-----------------------------------------
//  in_      | slave     | in_tvalid/in_tready  | tdata: symbol; tuser: restart
//  out_     | master    | out_tvalid/out_tready| tdata: new_state..state_count; tuser: overflow
//
// One item at a time: a new symbol is accepted only once the sequencer is back in idle.
// An ignored symbol (length limit or out of range) goes from load through root straight
// to output. A normal symbol runs alloc, new length, one walk step per state visited on
// the suffix-link walk, plus the q reads (QA, QB) when the walk stops at an existing
// transition; a clone adds a copy step per transition, a read and a check per state
// checked while redirecting, then the link update. Each step is one access to the single-port-read state memories.
// Synchronous active-low reset clears control state; the root row is rewritten on the
// first item after reset or restart, so no clearing pass is needed.
// A finished result waits in the output register while the next item is accepted;
// the sequencer stalls at its last step only if that register is still full.
module suffix_automaton_builder_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [3:0] symbol, [7:4] zero
  input  logic [sab_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] restart
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [10:0] new_state, [21:11] link_state, [32:22] repeat_len, [33] cloned,
  // [44:34] state_count, [47:45] zero
  output logic [sab_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [0] overflow
  output logic                            out_tuser
);

  sab_pkg::dp_op_t     op;
  sab_pkg::dp_status_t st;

  sab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .op        (op)
  );

  sab_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .st         (st),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== rtl/core/sab_ctrl.sv =====
// Sequencer of the suffix automaton builder: walks, clone copy and redirect.
module sab_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  sab_pkg::dp_status_t st,
  output sab_pkg::dp_op_t     op
);

  sab_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sab_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = sab_pkg::OP_NONE;
    in_tready = 1'b0;
    unique case (state_r)
      sab_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op        = sab_pkg::OP_LOAD;
          state_nxt = sab_pkg::ST_ROOT;
        end
      end
      sab_pkg::ST_ROOT: begin
        op        = sab_pkg::OP_ROOT;
        state_nxt = st.ovf ? sab_pkg::ST_OUT : sab_pkg::ST_ALLOC;
      end
      sab_pkg::ST_ALLOC: begin
        op        = sab_pkg::OP_ALLOC;
        state_nxt = sab_pkg::ST_NEWLEN;
      end
      sab_pkg::ST_NEWLEN: begin
        op        = sab_pkg::OP_NEWLEN;
        state_nxt = sab_pkg::ST_WALK;
      end
      sab_pkg::ST_WALK: begin
        op = sab_pkg::OP_WALK;
        if (st.bit_set) begin
          state_nxt = sab_pkg::ST_QA;
        end else if (st.p_zero) begin
          state_nxt = sab_pkg::ST_FIN;
        end
      end
      sab_pkg::ST_QA: begin
        op        = sab_pkg::OP_QA;
        state_nxt = sab_pkg::ST_QB;
      end
      sab_pkg::ST_QB: begin
        op        = sab_pkg::OP_QB;
        state_nxt = st.len_match ? sab_pkg::ST_FIN : sab_pkg::ST_COPY;
      end
      sab_pkg::ST_COPY: begin
        op = sab_pkg::OP_COPY;
        if (st.k_last) begin
          state_nxt = sab_pkg::ST_RRD;
        end
      end
      sab_pkg::ST_RRD: begin
        op        = sab_pkg::OP_RRD;
        state_nxt = sab_pkg::ST_RCHK;
      end
      sab_pkg::ST_RCHK: begin
        op        = sab_pkg::OP_RCHK;
        state_nxt = (st.redir_hit && !st.p_zero) ? sab_pkg::ST_RRD : sab_pkg::ST_REND;
      end
      sab_pkg::ST_REND: begin
        op        = sab_pkg::OP_REND;
        state_nxt = sab_pkg::ST_FIN;
      end
      sab_pkg::ST_FIN: begin
        op        = sab_pkg::OP_FIN;
        state_nxt = sab_pkg::ST_OUT;
      end
      sab_pkg::ST_OUT: begin
        op = sab_pkg::OP_OUT;
        if (st.out_free) begin
          state_nxt = sab_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sab_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/sab_datapath.sv =====
// Datapath of the suffix automaton builder: state memories, pointers, result register.
module sab_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sab_pkg::dp_op_t                      op,
  output sab_pkg::dp_status_t                  st,
  input  logic [sab_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [sab_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 out_tuser
);

  localparam int MAX_STRING = sab_pkg::MAX_STRING;
  localparam int ALPHABET   = sab_pkg::ALPHABET;
  localparam int NS = 2 * MAX_STRING;
  localparam int SW = $clog2(NS);
  localparam int LW = $clog2(MAX_STRING + 1);
  localparam int CW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int NT = NS * ALPHABET;
  localparam int AW = $clog2(NT);
  localparam int FW = sab_pkg::FIELD_W;
  localparam int SYW = sab_pkg::SYM_W;
  localparam int PADW = sab_pkg::OUT_TDATA_W - 4 * FW - 1;

  logic [ALPHABET-1:0] pres_mem [NS];
  logic [LW-1:0]       len_mem  [NS];
  logic [SW-1:0]       link_mem [NS];
  logic [SW-1:0]       tgt_mem  [NT];

  logic [ALPHABET-1:0] pres_rd, pres_wd;
  logic [LW-1:0]       len_rd, len_wd;
  logic [SW-1:0]       link_rd, link_wd, tgt_rd, tgt_wd;
  logic [SW-1:0]       pres_ra, pres_wa, len_ra, len_wa, link_ra, link_wa;
  logic [AW-1:0]       tgt_ra, tgt_wa;
  logic                pres_we, len_we, link_we, tgt_we;

  logic [SYW-1:0] sym_r;
  logic [SW-1:0]  last_r, used_r, cur_r, p_r, q_r, cp_r, lnk_r;
  logic [LW-1:0]  slen_r, lenp_r;
  logic [CW-1:0]  k_r;
  logic           cloned_r, ovf_r, root_init_r;
  logic           out_valid_r;
  logic [FW-1:0]  o_new_r, o_link_r, o_rep_r, o_cnt_r;
  logic           o_cloned_r, o_ovf_r;

  logic [CW-1:0]       c_idx;
  logic [ALPHABET-1:0] c_mask;
  logic [SW-1:0]       used_inc;
  logic [AW-1:0]       p_addr;
  logic                bit_set;

  function automatic logic [AW-1:0] taddr(input logic [SW-1:0] s, input logic [AW-1:0] i);
    return AW'(AW'(s) * AW'(ALPHABET)) + i;
  endfunction

  assign c_idx    = CW'(sym_r);
  assign c_mask   = {{(ALPHABET - 1){1'b0}}, 1'b1} << c_idx;
  assign used_inc = used_r + SW'(1);
  assign p_addr   = taddr(p_r, AW'(c_idx));
  assign bit_set  = pres_rd[c_idx];

  assign st.ovf       = (32'(slen_r) >= 32'(MAX_STRING)) || (32'(sym_r) >= 32'(ALPHABET));
  assign st.bit_set   = bit_set;
  assign st.p_zero    = (p_r == '0);
  assign st.len_match = ({1'b0, len_rd} == ({1'b0, lenp_r} + (LW + 1)'(1)));
  assign st.redir_hit = bit_set && (tgt_rd == q_r);
  assign st.k_last    = (k_r == CW'(ALPHABET - 1));
  assign st.out_free  = !out_valid_r || out_tready;

  // Memory addresses and writes for each step.
  always_comb begin
    pres_ra = '0; len_ra = '0; link_ra = '0; tgt_ra = '0;
    pres_we = 1'b0; pres_wa = '0; pres_wd = '0;
    len_we  = 1'b0; len_wa  = '0; len_wd  = '0;
    link_we = 1'b0; link_wa = '0; link_wd = '0;
    tgt_we  = 1'b0; tgt_wa  = '0; tgt_wd  = '0;
    case (op)
      sab_pkg::OP_ROOT: begin
        pres_we = !root_init_r;
        len_we  = !root_init_r;
      end
      sab_pkg::OP_ALLOC: begin
        len_ra  = last_r;
        pres_we = 1'b1;
        pres_wa = used_inc;
      end
      sab_pkg::OP_NEWLEN: begin
        len_we  = 1'b1;
        len_wa  = cur_r;
        len_wd  = len_rd + LW'(1);
        pres_ra = p_r;
        link_ra = p_r;
      end
      sab_pkg::OP_WALK: begin
        tgt_ra  = p_addr;
        len_ra  = p_r;
        pres_ra = link_rd;
        link_ra = link_rd;
        if (!bit_set) begin
          pres_we = 1'b1;
          pres_wa = p_r;
          pres_wd = pres_rd | c_mask;
          tgt_we  = 1'b1;
          tgt_wa  = p_addr;
          tgt_wd  = cur_r;
        end
      end
      sab_pkg::OP_QA: begin
        len_ra  = tgt_rd;
        link_ra = tgt_rd;
        pres_ra = tgt_rd;
      end
      sab_pkg::OP_QB: begin
        tgt_ra = taddr(q_r, AW'(k_r));
        if (!st.len_match) begin
          len_we  = 1'b1;
          len_wa  = used_inc;
          len_wd  = lenp_r + LW'(1);
          link_we = 1'b1;
          link_wa = used_inc;
          link_wd = link_rd;
          pres_we = 1'b1;
          pres_wa = used_inc;
          pres_wd = pres_rd;
        end
      end
      sab_pkg::OP_COPY: begin
        tgt_we = 1'b1;
        tgt_wa = taddr(cp_r, AW'(k_r));
        tgt_wd = tgt_rd;
        tgt_ra = taddr(q_r, AW'(k_r) + AW'(1));
      end
      sab_pkg::OP_RRD: begin
        pres_ra = p_r;
        tgt_ra  = p_addr;
        link_ra = p_r;
      end
      sab_pkg::OP_RCHK: begin
        if (st.redir_hit) begin
          tgt_we = 1'b1;
          tgt_wa = p_addr;
          tgt_wd = cp_r;
        end
      end
      sab_pkg::OP_REND: begin
        link_we = 1'b1;
        link_wa = q_r;
        link_wd = cp_r;
      end
      sab_pkg::OP_FIN: begin
        link_we = 1'b1;
        link_wa = cur_r;
        link_wd = lnk_r;
        len_ra  = lnk_r;
      end
      sab_pkg::OP_OUT: begin
        len_ra = lnk_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pres_rd <= pres_mem[pres_ra];
    if (pres_we) begin
      pres_mem[pres_wa] <= pres_wd;
    end
  end

  always_ff @(posedge clk) begin
    len_rd <= len_mem[len_ra];
    if (len_we) begin
      len_mem[len_wa] <= len_wd;
    end
  end

  always_ff @(posedge clk) begin
    link_rd <= link_mem[link_ra];
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
  end

  always_ff @(posedge clk) begin
    tgt_rd <= tgt_mem[tgt_ra];
    if (tgt_we) begin
      tgt_mem[tgt_wa] <= tgt_wd;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= '0;
      used_r      <= '0;
      slen_r      <= '0;
      root_init_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (op)
        sab_pkg::OP_LOAD: begin
          if (in_tuser) begin
            last_r      <= '0;
            used_r      <= '0;
            slen_r      <= '0;
            root_init_r <= 1'b0;
          end
        end
        sab_pkg::OP_ROOT:  root_init_r <= 1'b1;
        sab_pkg::OP_ALLOC: used_r <= used_inc;
        sab_pkg::OP_QB: begin
          if (!st.len_match) begin
            used_r <= used_inc;
          end
        end
        sab_pkg::OP_FIN: begin
          last_r <= cur_r;
          slen_r <= slen_r + LW'(1);
        end
        sab_pkg::OP_OUT: begin
          if (st.out_free) begin
            out_valid_r <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (op)
      sab_pkg::OP_LOAD: sym_r <= in_tdata[SYW-1:0];
      sab_pkg::OP_ROOT: ovf_r <= st.ovf;
      sab_pkg::OP_ALLOC: begin
        cur_r    <= used_inc;
        p_r      <= last_r;
        cloned_r <= 1'b0;
        k_r      <= '0;
      end
      sab_pkg::OP_WALK: begin
        if (!bit_set) begin
          if (p_r == '0) begin
            lnk_r <= '0;
          end else begin
            p_r <= link_rd;
          end
        end
      end
      sab_pkg::OP_QA: begin
        q_r    <= tgt_rd;
        lenp_r <= len_rd;
      end
      sab_pkg::OP_QB: begin
        if (st.len_match) begin
          lnk_r <= q_r;
        end else begin
          cp_r     <= used_inc;
          cloned_r <= 1'b1;
        end
      end
      sab_pkg::OP_COPY: k_r <= k_r + CW'(1);
      sab_pkg::OP_RCHK: begin
        if (st.redir_hit && (p_r != '0)) begin
          p_r <= link_rd;
        end
      end
      sab_pkg::OP_REND: lnk_r <= cp_r;
      sab_pkg::OP_OUT: begin
        if (st.out_free) begin
          o_cnt_r <= FW'({1'b0, used_r} + (SW + 1)'(1));
          o_ovf_r <= ovf_r;
          if (ovf_r) begin
            o_new_r    <= '0;
            o_link_r   <= '0;
            o_rep_r    <= '0;
            o_cloned_r <= 1'b0;
          end else begin
            o_new_r    <= FW'(cur_r);
            o_link_r   <= FW'(lnk_r);
            o_rep_r    <= FW'(len_rd);
            o_cloned_r <= cloned_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PADW{1'b0}}, o_cnt_r, o_cloned_r, o_rep_r, o_link_r, o_new_r};
  assign out_tuser  = o_ovf_r;

endmodule
